// ===== hdl/complex_accumulator_alu_assert.svh =====
// Assertion macros for the complex accumulator.
`ifndef COMPLEX_ACCUMULATOR_ALU_ASSERT_SVH
`define COMPLEX_ACCUMULATOR_ALU_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define CAA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CAA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/caa_pkg.sv =====
// ----------------------------------------------------------------------------
// caa_pkg
// Shared widths, command codes and the saturation helper of the complex
// accumulator.
// ----------------------------------------------------------------------------
package caa_pkg;

  localparam int DATA_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = 2 * DATA_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int NUM_W      = PROD_W + FRAC_W;
  localparam int UNIT_W     = PROD_W + 1;
  localparam int DIV_STEPS  = NUM_W;
  localparam int SQRT_STEPS = DATA_W;

  // Command codes.
  localparam logic [2:0] ACT_LOAD = 3'd0;
  localparam logic [2:0] ACT_MAG  = 3'd1;
  localparam logic [2:0] ACT_ADD  = 3'd2;
  localparam logic [2:0] ACT_SUB  = 3'd3;
  localparam logic [2:0] ACT_MUL  = 3'd4;
  localparam logic [2:0] ACT_DIV  = 3'd5;

  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic              ov;
  } sat_t;

  // Turns a sign and magnitude into a saturated two's complement value.
  function automatic sat_t caa_sat(input logic neg, input logic [NUM_W-1:0] mag);
    logic [NUM_W-1:0]  lim;
    logic [DATA_W-1:0] m;
    sat_t              r;
    lim   = neg ? (NUM_W'(1) << (DATA_W - 1))
                : ((NUM_W'(1) << (DATA_W - 1)) - NUM_W'(1));
    r.ov  = mag > lim;
    m     = r.ov ? lim[DATA_W-1:0] : mag[DATA_W-1:0];
    r.val = neg ? (~m + DATA_W'(1)) : m;
    return r;
  endfunction

endpackage

// ===== hdl/caa_mul.sv =====
// ----------------------------------------------------------------------------
// caa_mul
// Registered signed multiplier shared by all product steps.
// ----------------------------------------------------------------------------
module caa_mul (
  input  logic                                  clk_i,
  input  logic signed [caa_pkg::DATA_W-1:0]     a_i,
  input  logic signed [caa_pkg::DATA_W-1:0]     b_i,
  output logic signed [caa_pkg::PROD_W-1:0]     p_o
);

  logic signed [caa_pkg::PROD_W-1:0] p_q;

  // One product per cycle, registered.
  always_ff @(posedge clk_i) begin
    p_q <= a_i * b_i;
  end

  assign p_o = p_q;

endmodule

// ===== hdl/caa_csub.sv =====
// ----------------------------------------------------------------------------
// caa_csub
// Shared compare and subtract unit for the division and square root steps.
// ----------------------------------------------------------------------------
module caa_csub (
  input  logic [caa_pkg::UNIT_W-1:0] a_i,
  input  logic [caa_pkg::UNIT_W-1:0] b_i,
  output logic                       ge_o,
  output logic [caa_pkg::UNIT_W-1:0] diff_o
);

  // The trial subtraction and its outcome.
  assign ge_o   = a_i >= b_i;
  assign diff_o = a_i - b_i;

endmodule

// ===== hdl/complex_accumulator_alu.sv =====
// ----------------------------------------------------------------------------
// complex_accumulator_alu
// Complex Q16.16 accumulator: load, magnitude, add, subtract, multiply and
// divide, with saturation, on one multiplier and one compare-subtract unit.
// ----------------------------------------------------------------------------
//  Channel | Handshake                    | Payload
//  in      | in_valid_i / in_stall_o      | action_i, operand_real_i, operand_imag_i
//  out     | out_valid_o / out_stall_i    | value_real_o, value_imag_o, magnitude_o,
//          |                              | divide_by_zero_o, overflow_o
//
// Load, add, subtract, unused codes and a division by zero run no products;
// the rest run their products first; magnitude then takes one root bit per
// cycle, divide one quotient bit per cycle (80 per part) on caa_csub.
// Reset clears the accumulator to zero and empties the output register.
// The block takes one item at a time; a finished result waits in the output
// register while out_stall_i is high, and the next item may already be taken.
// ----------------------------------------------------------------------------
module complex_accumulator_alu (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [2:0]                          action_i,
  input  logic signed [caa_pkg::DATA_W-1:0]   operand_real_i,
  input  logic signed [caa_pkg::DATA_W-1:0]   operand_imag_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [caa_pkg::DATA_W-1:0]   value_real_o,
  output logic signed [caa_pkg::DATA_W-1:0]   value_imag_o,
  output logic [caa_pkg::DATA_W-1:0]          magnitude_o,
  output logic                                divide_by_zero_o,
  output logic                                overflow_o
);

  `include "complex_accumulator_alu_assert.svh"

  localparam int DW = caa_pkg::DATA_W;
  localparam int SW = caa_pkg::SUM_W;
  localparam int NW = caa_pkg::NUM_W;
  localparam int UW = caa_pkg::UNIT_W;
  localparam int PW = caa_pkg::PROD_W;
  localparam int FW = caa_pkg::FRAC_W;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MULT = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_SQRT = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]             state_q, state_d;
  logic [2:0]             act_q, act_d;
  logic signed [DW-1:0]   c_q, c_d, d_q, d_d;
  logic signed [DW-1:0]   acc_re_q, acc_re_d, acc_im_q, acc_im_d;
  logic signed [SW-1:0]   s0_q, s0_d, s1_q, s1_d, s2_q, s2_d;
  logic [2:0]             pcnt_q, pcnt_d;
  logic                   pv_q, pv_d, pneg_q, pneg_d;
  logic [1:0]             pdst_q, pdst_d;
  logic [NW-1:0]          nq_q, nq_d;
  logic [PW-1:0]          rem_q, rem_d;
  logic [DW-1:0]          root_q, root_d;
  logic [6:0]             it_q, it_d;
  logic                   part_q, part_d;
  logic [DW-1:0]          res_re_q, res_re_d, res_im_q, res_im_d, mag_q, mag_d;
  logic                   dz_q, dz_d, ov_q, ov_d;
  logic                   out_valid_q, out_valid_d;
  logic [DW-1:0]          out_re_q, out_re_d, out_im_q, out_im_d, out_mag_q, out_mag_d;
  logic                   out_dz_q, out_dz_d, out_ov_q, out_ov_d;

  logic signed [DW-1:0]   mul_a, mul_b;
  logic signed [PW-1:0]   mul_p;
  logic [2:0]             nprod;
  logic [1:0]             iss_dst;
  logic                   iss_neg, issue;
  logic signed [SW-1:0]   p_ext, term;
  logic [SW-1:0]          s0_abs, s1_abs;
  logic [UW-1:0]          u_a, u_b, u_diff;
  logic                   u_ge;
  logic signed [DW:0]     ar, ai;
  logic [DW:0]            ar_abs, ai_abs;
  logic [NW-1:0]          quo;
  caa_pkg::sat_t          sat_a, sat_b;

  // Product schedule for each command: operands, target sum and sign.
  always_comb begin
    nprod   = 3'd0;
    mul_a   = acc_re_q;
    mul_b   = acc_re_q;
    iss_dst = 2'd0;
    iss_neg = 1'b0;
    case (act_q)
      caa_pkg::ACT_MAG: begin
        nprod = 3'd2;
        if (pcnt_q == 3'd1) begin
          mul_a = acc_im_q;
          mul_b = acc_im_q;
        end
      end
      caa_pkg::ACT_MUL: begin
        nprod = 3'd4;
        case (pcnt_q)
          3'd0: begin mul_a = acc_re_q; mul_b = c_q; end
          3'd1: begin mul_a = acc_im_q; mul_b = d_q; iss_neg = 1'b1; end
          3'd2: begin mul_a = acc_re_q; mul_b = d_q; iss_dst = 2'd1; end
          default: begin mul_a = acc_im_q; mul_b = c_q; iss_dst = 2'd1; end
        endcase
      end
      caa_pkg::ACT_DIV: begin
        nprod = 3'd6;
        case (pcnt_q)
          3'd0: begin mul_a = c_q; mul_b = c_q; iss_dst = 2'd2; end
          3'd1: begin mul_a = d_q; mul_b = d_q; iss_dst = 2'd2; end
          3'd2: begin mul_a = acc_re_q; mul_b = c_q; end
          3'd3: begin mul_a = acc_im_q; mul_b = d_q; end
          3'd4: begin mul_a = acc_im_q; mul_b = c_q; iss_dst = 2'd1; end
          default: begin
            mul_a = acc_re_q; mul_b = d_q; iss_dst = 2'd1; iss_neg = 1'b1;
          end
        endcase
      end
      default: nprod = 3'd0;
    endcase
  end

  caa_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // Magnitudes of the sums, and the signed term to accumulate.
  assign s0_abs = s0_q[SW-1] ? (~s0_q + SW'(1)) : s0_q;
  assign s1_abs = s1_q[SW-1] ? (~s1_q + SW'(1)) : s1_q;
  assign p_ext  = SW'(mul_p);
  assign term   = pneg_q ? -p_ext : p_ext;

  // Operand selection for the shared compare-subtract unit.
  assign u_a = (state_q == ST_DIV) ? {rem_q, nq_q[NW-1]} : {rem_q[PW-2:0], nq_q[NW-1:NW-2]};
  assign u_b = (state_q == ST_DIV) ? {1'b0, s2_q[PW-1:0]}
                                   : {(UW-DW-2)'(0), root_q, 2'b01};

  caa_csub u_csub (
    .a_i    (u_a),
    .b_i    (u_b),
    .ge_o   (u_ge),
    .diff_o (u_diff)
  );

  // Add and subtract on the incoming operand.
  assign ar     = (action_i == caa_pkg::ACT_ADD)
                  ? ({acc_re_q[DW-1], acc_re_q} + {operand_real_i[DW-1], operand_real_i})
                  : ({acc_re_q[DW-1], acc_re_q} - {operand_real_i[DW-1], operand_real_i});
  assign ai     = (action_i == caa_pkg::ACT_ADD)
                  ? ({acc_im_q[DW-1], acc_im_q} + {operand_imag_i[DW-1], operand_imag_i})
                  : ({acc_im_q[DW-1], acc_im_q} - {operand_imag_i[DW-1], operand_imag_i});
  assign ar_abs = ar[DW] ? (~ar + (DW+1)'(1)) : ar;
  assign ai_abs = ai[DW] ? (~ai + (DW+1)'(1)) : ai;
  assign quo    = {nq_q[NW-2:0], u_ge};
  assign issue  = pcnt_q < nprod;

  // Sequencer and datapath next state.
  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    c_d         = c_q;
    d_d         = d_q;
    acc_re_d    = acc_re_q;
    acc_im_d    = acc_im_q;
    s0_d        = s0_q;
    s1_d        = s1_q;
    s2_d        = s2_q;
    pcnt_d      = pcnt_q;
    pv_d        = 1'b0;
    pneg_d      = pneg_q;
    pdst_d      = pdst_q;
    nq_d        = nq_q;
    rem_d       = rem_q;
    root_d      = root_q;
    it_d        = it_q;
    part_d      = part_q;
    res_re_d    = res_re_q;
    res_im_d    = res_im_q;
    mag_d       = mag_q;
    dz_d        = dz_q;
    ov_d        = ov_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_re_d    = out_re_q;
    out_im_d    = out_im_q;
    out_mag_d   = out_mag_q;
    out_dz_d    = out_dz_q;
    out_ov_d    = out_ov_q;
    sat_a       = caa_pkg::caa_sat(1'b0, NW'(0));
    sat_b       = caa_pkg::caa_sat(1'b0, NW'(0));
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          act_d    = action_i;
          c_d      = operand_real_i;
          d_d      = operand_imag_i;
          s0_d     = '0;
          s1_d     = '0;
          s2_d     = '0;
          pcnt_d   = 3'd0;
          res_re_d = acc_re_q;
          res_im_d = acc_im_q;
          mag_d    = '0;
          dz_d     = 1'b0;
          ov_d     = 1'b0;
          state_d  = ST_DONE;
          case (action_i)
            caa_pkg::ACT_LOAD: begin
              res_re_d = operand_real_i;
              res_im_d = operand_imag_i;
            end
            caa_pkg::ACT_ADD, caa_pkg::ACT_SUB: begin
              sat_a    = caa_pkg::caa_sat(ar[DW], NW'(ar_abs));
              sat_b    = caa_pkg::caa_sat(ai[DW], NW'(ai_abs));
              res_re_d = sat_a.val;
              res_im_d = sat_b.val;
              ov_d     = sat_a.ov | sat_b.ov;
            end
            caa_pkg::ACT_MAG, caa_pkg::ACT_MUL: state_d = ST_MULT;
            caa_pkg::ACT_DIV: begin
              if (operand_real_i == '0 && operand_imag_i == '0) begin
                dz_d = 1'b1;
              end else begin
                state_d = ST_MULT;
              end
            end
            default: state_d = ST_DONE;
          endcase
        end
      end
      ST_MULT: begin
        pv_d   = issue;
        pdst_d = iss_dst;
        pneg_d = iss_neg;
        if (issue) begin
          pcnt_d = pcnt_q + 3'd1;
        end
        if (pv_q) begin
          case (pdst_q)
            2'd0:    s0_d = s0_q + term;
            2'd1:    s1_d = s1_q + term;
            default: s2_d = s2_q + term;
          endcase
        end
        if (!issue && !pv_q) begin
          rem_d  = '0;
          root_d = '0;
          it_d   = '0;
          part_d = 1'b0;
          case (act_q)
            caa_pkg::ACT_MAG: begin
              nq_d    = {s0_q[PW-1:0], FW'(0)};
              state_d = ST_SQRT;
            end
            caa_pkg::ACT_DIV: begin
              nq_d    = {s0_abs[PW-1:0], FW'(0)};
              state_d = ST_DIV;
            end
            default: state_d = ST_FIN;
          endcase
        end
      end
      ST_DIV: begin
        rem_d = u_ge ? u_diff[PW-1:0] : u_a[PW-1:0];
        nq_d  = quo;
        it_d  = it_q + 7'd1;
        if (it_q == 7'(caa_pkg::DIV_STEPS - 1)) begin
          if (!part_q) begin
            sat_a    = caa_pkg::caa_sat(s0_q[SW-1], quo);
            res_re_d = sat_a.val;
            ov_d     = ov_q | sat_a.ov;
            nq_d     = {s1_abs[PW-1:0], FW'(0)};
            rem_d    = '0;
            it_d     = '0;
            part_d   = 1'b1;
          end else begin
            sat_a    = caa_pkg::caa_sat(s1_q[SW-1], quo);
            res_im_d = sat_a.val;
            ov_d     = ov_q | sat_a.ov;
            state_d  = ST_DONE;
          end
        end
      end
      ST_SQRT: begin
        rem_d  = u_ge ? u_diff[PW-1:0] : u_a[PW-1:0];
        root_d = {root_q[DW-2:0], u_ge};
        nq_d   = {nq_q[NW-3:0], 2'b00};
        it_d   = it_q + 7'd1;
        if (it_q == 7'(caa_pkg::SQRT_STEPS - 1)) begin
          mag_d   = {root_q[DW-2:0], u_ge};
          state_d = ST_DONE;
        end
      end
      ST_FIN: begin
        sat_a    = caa_pkg::caa_sat(s0_q[SW-1], NW'(s0_abs >> FW));
        sat_b    = caa_pkg::caa_sat(s1_q[SW-1], NW'(s1_abs >> FW));
        res_re_d = sat_a.val;
        res_im_d = sat_b.val;
        ov_d     = sat_a.ov | sat_b.ov;
        state_d  = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_re_d    = res_re_q;
          out_im_d    = res_im_q;
          out_mag_d   = mag_q;
          out_dz_d    = dz_q;
          out_ov_d    = ov_q;
          acc_re_d    = res_re_q;
          acc_im_d    = res_im_q;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      acc_re_q    <= '0;
      acc_im_q    <= '0;
      pv_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_re_q    <= acc_re_d;
      acc_im_q    <= acc_im_d;
      pv_q        <= pv_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    act_q     <= act_d;
    c_q       <= c_d;
    d_q       <= d_d;
    s0_q      <= s0_d;
    s1_q      <= s1_d;
    s2_q      <= s2_d;
    pcnt_q    <= pcnt_d;
    pneg_q    <= pneg_d;
    pdst_q    <= pdst_d;
    nq_q      <= nq_d;
    rem_q     <= rem_d;
    root_q    <= root_d;
    it_q      <= it_d;
    part_q    <= part_d;
    res_re_q  <= res_re_d;
    res_im_q  <= res_im_d;
    mag_q     <= mag_d;
    dz_q      <= dz_d;
    ov_q      <= ov_d;
    out_re_q  <= out_re_d;
    out_im_q  <= out_im_d;
    out_mag_q <= out_mag_d;
    out_dz_q  <= out_dz_d;
    out_ov_q  <= out_ov_d;
  end

  assign in_stall_o       = state_q != ST_IDLE;
  assign out_valid_o      = out_valid_q;
  assign value_real_o     = out_re_q;
  assign value_imag_o     = out_im_q;
  assign magnitude_o      = out_mag_q;
  assign divide_by_zero_o = out_dz_q;
  assign overflow_o       = out_ov_q;

  // An accepted item keeps the input side closed in the next cycle.
  `CAA_ASSERT_NEXT(a_busy_after_accept, in_valid_i && !in_stall_o, in_stall_o,
                   "input accepted twice in a row")
  // A skipped division reports neither overflow nor a magnitude.
  `CAA_ASSERT_NOW(a_dz_clean, out_valid_o && divide_by_zero_o,
                  !overflow_o && magnitude_o == '0, "divide by zero with other flags")
  // A magnitude result never comes with overflow.
  `CAA_ASSERT_NOW(a_mag_no_ov, out_valid_o && magnitude_o != '0,
                  !overflow_o && !divide_by_zero_o, "magnitude result with a flag")

endmodule

// ===== dv/complex_accumulator_alu_test.sv =====
// ----------------------------------------------------------------------------
// complex_accumulator_alu_test
// Drives command items into the complex accumulator with random gaps and
// output stalls, predicts every result with wide integer arithmetic, and
// compares each result field by field in arrival order.
// ----------------------------------------------------------------------------
module complex_accumulator_alu_test;

  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [caa_pkg::DATA_W-1:0] re;
    logic [caa_pkg::DATA_W-1:0] im;
    logic [caa_pkg::DATA_W-1:0] mag;
    logic                       dz;
    logic                       ov;
  } outcome_t;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              in_valid_i;
  logic                              in_stall_o;
  logic [2:0]                        action_i;
  logic signed [caa_pkg::DATA_W-1:0] operand_real_i;
  logic signed [caa_pkg::DATA_W-1:0] operand_imag_i;
  logic                              out_valid_o;
  logic                              out_stall_i;
  logic signed [caa_pkg::DATA_W-1:0] value_real_o;
  logic signed [caa_pkg::DATA_W-1:0] value_imag_o;
  logic [caa_pkg::DATA_W-1:0]        magnitude_o;
  logic                              divide_by_zero_o;
  logic                              overflow_o;

  complex_accumulator_alu dut (.*);

  // Predicted accumulator state.
  logic signed [caa_pkg::DATA_W-1:0] acc_re;
  logic signed [caa_pkg::DATA_W-1:0] acc_im;

  outcome_t pending_q[$];
  int       mismatch_count;
  int       sent_count;
  int       checked_count;
  int       idle_cycles;
  bit       hold_off;
  bit       sink_idle_enable;

  // Clock generation.
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Clamps an exact signed value to the data range.
  function automatic logic [caa_pkg::DATA_W-1:0] clamp(input logic signed [191:0] v,
                                                       inout logic ov);
    logic signed [191:0] hi;
    logic signed [191:0] lo;
    hi = (192'sd1 <<< (caa_pkg::DATA_W - 1)) - 1;
    lo = -(192'sd1 <<< (caa_pkg::DATA_W - 1));
    if (v > hi) begin
      ov = 1'b1;
      return hi[caa_pkg::DATA_W-1:0];
    end
    if (v < lo) begin
      ov = 1'b1;
      return lo[caa_pkg::DATA_W-1:0];
    end
    return v[caa_pkg::DATA_W-1:0];
  endfunction

  // Integer square root by bisection on the squared length.
  function automatic logic [191:0] isqrt(input logic [191:0] n);
    logic [191:0] lo;
    logic [191:0] hi;
    logic [191:0] mid;
    lo = 0;
    hi = 192'd1 << 66;
    while (hi - lo > 1) begin
      mid = (lo + hi) >> 1;
      if (mid * mid <= n) lo = mid;
      else hi = mid;
    end
    return lo;
  endfunction

  // Computes the expected result of one command and updates the accumulator.
  function automatic outcome_t accumulate(input logic [2:0] act,
                                          input logic signed [caa_pkg::DATA_W-1:0] c,
                                          input logic signed [caa_pkg::DATA_W-1:0] d);
    outcome_t r;
    logic signed [191:0] e, f, cc, dd, nr, ni, den;
    logic [191:0] m;
    e = acc_re;
    f = acc_im;
    cc = c;
    dd = d;
    r.mag = '0;
    r.dz = 1'b0;
    r.ov = 1'b0;
    case (act)
      caa_pkg::ACT_LOAD: begin
        acc_re = c;
        acc_im = d;
      end
      caa_pkg::ACT_MAG: begin
        m = isqrt(e * e + f * f);
        r.mag = (m > 192'hFFFF_FFFF) ? '1 : m[caa_pkg::DATA_W-1:0];
      end
      caa_pkg::ACT_ADD: begin
        acc_re = clamp(e + cc, r.ov);
        acc_im = clamp(f + dd, r.ov);
      end
      caa_pkg::ACT_SUB: begin
        acc_re = clamp(e - cc, r.ov);
        acc_im = clamp(f - dd, r.ov);
      end
      caa_pkg::ACT_MUL: begin
        nr = (e * cc - f * dd) / (192'sd1 <<< caa_pkg::FRAC_W);
        ni = (e * dd + f * cc) / (192'sd1 <<< caa_pkg::FRAC_W);
        acc_re = clamp(nr, r.ov);
        acc_im = clamp(ni, r.ov);
      end
      caa_pkg::ACT_DIV: begin
        if (c == 0 && d == 0) begin
          r.dz = 1'b1;
        end else begin
          den = cc * cc + dd * dd;
          nr = ((e * cc + f * dd) * (192'sd1 <<< caa_pkg::FRAC_W)) / den;
          ni = ((f * cc - e * dd) * (192'sd1 <<< caa_pkg::FRAC_W)) / den;
          acc_re = clamp(nr, r.ov);
          acc_im = clamp(ni, r.ov);
        end
      end
      default: begin
      end
    endcase
    r.re = acc_re;
    r.im = acc_im;
    return r;
  endfunction

  // Offers one item after a random gap and waits for it to be taken.
  // Valid stays up after an accept until the next call either drops it for a
  // gap or puts the next item on the bus in the same step.
  task automatic send_command(input logic [2:0] act, input logic [caa_pkg::DATA_W-1:0] c,
                              input logic [caa_pkg::DATA_W-1:0] d);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    action_i       <= act;
    operand_real_i <= c;
    operand_imag_i <= d;
    do @(posedge clk_i); while (in_stall_o);
    pending_q.push_back(accumulate(act, c, d));
    sent_count++;
  endtask

  // Draws an operand part, weighted toward edges and small values.
  function automatic logic [caa_pkg::DATA_W-1:0] pick_part();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 1) ? 32'h0 : 32'h0001_0000;
      3: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_directed();
    send_command(caa_pkg::ACT_MAG, 0, 0);
    send_command(caa_pkg::ACT_LOAD, 32'h7FFF_FFFF, 32'h8000_0000);
    send_command(caa_pkg::ACT_MAG, 0, 0);
    send_command(caa_pkg::ACT_ADD, 32'h7FFF_FFFF, 32'h8000_0000);
    send_command(caa_pkg::ACT_SUB, 32'h8000_0000, 32'h7FFF_FFFF);
    send_command(caa_pkg::ACT_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_command(caa_pkg::ACT_LOAD, 32'h0003_0000, 32'hFFFC_0000);
    send_command(caa_pkg::ACT_MAG, 0, 0);
    send_command(caa_pkg::ACT_MUL, 32'h0001_0000, 32'h0002_0000);
    send_command(caa_pkg::ACT_DIV, 0, 0);
    send_command(caa_pkg::ACT_DIV, 32'h0001_0000, 32'hFFFF_0000);
    send_command(caa_pkg::ACT_DIV, 32'h0000_0001, 32'h0);
    send_command(3'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_command(3'd7, 0, 0);
    send_command(caa_pkg::ACT_LOAD, 32'h8000_0000, 32'h8000_0000);
    send_command(caa_pkg::ACT_MAG, 0, 0);
    send_command(caa_pkg::ACT_MUL, 32'h8000_0000, 32'h8000_0000);
    send_command(caa_pkg::ACT_LOAD, 32'hAAAA_5555, 32'h5555_AAAA);
    send_command(caa_pkg::ACT_DIV, 32'h8000_0000, 32'h7FFF_FFFF);
  endtask

  task automatic run_random(input int count);
    logic [2:0] act;
    repeat (count) begin
      act = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      send_command(act, pick_part(), pick_part());
    end
  endtask

  // Output stalls for a long stretch while items keep coming.
  task automatic run_backpressure();
    hold_off = 1'b1;
    fork
      run_random(6);
      begin
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
    join
  endtask

  // Receiver stall generation.
  initial begin
    int wait_cycles;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
      end else if (out_valid_o && !out_stall_i) begin
        wait_cycles = sink_idle_enable ? $urandom_range(0, 16) : 0;
        if (wait_cycles > 0) begin
          out_stall_i <= 1'b1;
          repeat (wait_cycles) @(posedge clk_i);
        end
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Result checking.
  always @(posedge clk_i) begin
    outcome_t x;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      checked_count++;
      if (pending_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("Unexpected result item re=%h", value_real_o);
      end else begin
        x = pending_q.pop_front();
        if (x.re !== value_real_o || x.im !== value_imag_o || x.mag !== magnitude_o ||
            x.dz !== divide_by_zero_o || x.ov !== overflow_o) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch: expected %h %h %h %b %b, got %h %h %h %b %b",
                     x.re, x.im, x.mag, x.dz, x.ov, value_real_o, value_imag_o,
                     magnitude_o, divide_by_zero_o, overflow_o);
        end
      end
    end
  end

  // Watchdog on cycles without progress.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || hold_off)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[complex_accumulator_alu] ERROR");
      $finish;
    end
  end

  initial begin
    int tail;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    action_i = '0;
    operand_real_i = '0;
    operand_imag_i = '0;
    sent_count = 0;
    hold_off = 1'b0;
    sink_idle_enable = 1'b1;
    acc_re = '0;
    acc_im = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    run_directed();
    run_random(600);
    run_backpressure();
    sink_idle_enable = 1'b0;
    run_random(200);
    sink_idle_enable = 1'b1;
    run_random(400);
    in_valid_i <= 1'b0;
    tail = 0;
    while (pending_q.size() != 0 && tail < 100000) begin
      @(posedge clk_i);
      tail++;
    end
    repeat (200) @(posedge clk_i);
    $display("Sent %0d commands of all six kinds plus unused codes; checked %0d results.",
             sent_count, checked_count);
    if (mismatch_count == 0 && pending_q.size() == 0) begin
      $display("[complex_accumulator_alu] OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count, pending_q.size());
      $display("[complex_accumulator_alu] ERROR");
    end
    $finish;
  end

endmodule
